>>> hw/rtl/rdws_pkg.sv
// ----------------------------------------------------------------------------
// rdws_pkg
// Types and codes shared by the record deque with sort.
// ----------------------------------------------------------------------------
package rdws_pkg;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 31;
    localparam int TOTAL_W = 35;
    localparam int COUNT_W = 5;

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SORT       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [KEY_W-1:0]   record_key;
        logic [VALUE_W-1:0] record_value;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0]   popped_key;
        logic [VALUE_W-1:0] popped_value;
        logic [COUNT_W-1:0] entry_count;
        logic [TOTAL_W-1:0] value_total;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_record;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SORT_P,
        S_SORT_Q,
        S_SORT_WB
    } t_state;

endpackage

>>> hw/rtl/rdws_ram.sv
// ----------------------------------------------------------------------------
// rdws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/record_deque_with_sort_core.sv
// ----------------------------------------------------------------------------
// record_deque_with_sort_core
// Double-ended queue of key/value records with an in-place exchange sort.
// ----------------------------------------------------------------------------
// A push result is registered on acceptance; a pop reads the record RAM and
// returns its result from S_POP. Each sort pass holds the record at position
// p in a register and compares it against one later record per cycle, all
// through the single read and write port of the record RAM. The input is
// stalled while an item is in progress or an output is held by i_out_stall.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module record_deque_with_sort_core
    import rdws_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = KEY_W + VALUE_W;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [AW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, front} + {1'b0, pos};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [AW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [AW-1:0]     r_p, n_p;
    logic [AW-1:0]     r_q, n_q;
    t_record           r_cur, n_cur;
    logic              r_pop_front, n_pop_front;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_record           ram_wdata;
    logic [AW-1:0]     ram_raddr;
    t_record           ram_rdata;
    logic [RW-1:0]     ram_rdata_raw;

    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic [CW-1:0]     count_m1;
    logic [AW-1:0]     last_pos;
    logic              q_last;
    logic              p_last;
    logic              swap;
    logic [AW-1:0]     p_inc;

    rdws_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata_raw)
    );

    assign ram_rdata = ram_rdata_raw;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign is_full    = (r_count >= CW'(DEPTH));
    assign is_empty   = (r_count == '0);
    assign count_m1   = r_count - CW'(1);
    assign last_pos   = count_m1[AW-1:0];
    assign q_last     = (r_q == last_pos);
    assign p_inc      = r_p + AW'(1);
    assign p_last     = (p_inc == last_pos);
    assign swap       = (r_cur.key > ram_rdata.key);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_item.operation)
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (!is_empty) begin
                                n_state = S_POP;
                            end
                        end
                        OP_SORT: begin
                            if (r_count >= CW'(2)) begin
                                n_state = S_SORT_P;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_POP:    n_state = S_IDLE;
            S_SORT_P: n_state = S_SORT_Q;
            S_SORT_Q: begin
                if (q_last) begin
                    n_state = S_SORT_WB;
                end
            end
            S_SORT_WB: n_state = p_last ? S_IDLE : S_SORT_P;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic      load_out;
        t_out_item res;
        n_front     = r_front;
        n_count     = r_count;
        n_total     = r_total;
        n_p         = r_p;
        n_q         = r_q;
        n_cur       = r_cur;
        n_pop_front = r_pop_front;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = r_cur;
        ram_raddr   = '0;
        load_out    = 1'b0;
        res         = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_item.operation)
                        OP_PUSH_BACK, OP_PUSH_FRONT: begin
                            load_out = 1'b1;
                            if (is_full) begin
                                res.status = ST_FULL;
                            end else begin
                                ram_we          = 1'b1;
                                ram_wdata.key   = i_in_item.record_key;
                                ram_wdata.value = i_in_item.record_value;
                                if (i_in_item.operation == OP_PUSH_BACK) begin
                                    ram_waddr = slot_of(r_front, r_count[AW-1:0]);
                                end else begin
                                    n_front = (r_front == '0) ? AW'(DEPTH - 1)
                                                              : r_front - AW'(1);
                                    ram_waddr = n_front;
                                end
                                n_count = r_count + CW'(1);
                                n_total = r_total + TOTAL_W'(i_in_item.record_value);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (is_empty) begin
                                load_out   = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                n_pop_front = (i_in_item.operation == OP_POP_FRONT);
                                ram_raddr   = n_pop_front ? r_front
                                                          : slot_of(r_front, last_pos);
                            end
                        end
                        OP_SORT: begin
                            if (r_count < CW'(2)) begin
                                load_out = 1'b1;
                            end else begin
                                n_p       = '0;
                                ram_raddr = r_front;
                            end
                        end
                        default: load_out = 1'b1;
                    endcase
                end
            end
            S_POP: begin
                load_out         = 1'b1;
                res.popped_key   = ram_rdata.key;
                res.popped_value = ram_rdata.value;
                n_count          = count_m1;
                n_total          = r_total - TOTAL_W'(ram_rdata.value);
                if (r_pop_front) begin
                    n_front = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
                end
            end
            S_SORT_P: begin
                n_cur     = ram_rdata;
                n_q       = p_inc;
                ram_raddr = slot_of(r_front, p_inc);
            end
            S_SORT_Q: begin
                if (swap) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(r_front, r_q);
                    ram_wdata = r_cur;
                    n_cur     = ram_rdata;
                end
                if (!q_last) begin
                    n_q       = r_q + AW'(1);
                    ram_raddr = slot_of(r_front, r_q + AW'(1));
                end
            end
            S_SORT_WB: begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(r_front, r_p);
                ram_wdata = r_cur;
                if (p_last) begin
                    load_out = 1'b1;
                end else begin
                    n_p       = p_inc;
                    ram_raddr = slot_of(r_front, p_inc);
                end
            end
            default: ;
        endcase

        res.entry_count = COUNT_W'(n_count);
        res.value_total = n_total;

        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_item  = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_p         <= n_p;
        r_q         <= n_q;
        r_cur       <= n_cur;
        r_pop_front <= n_pop_front;
        r_out_item  <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
